/* hdl/flc_pkg.sv */
// Shared types and constants for the free-look camera step core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package flc_pkg;

  typedef struct packed {
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic               key_forward;
    logic               key_backward;
    logic               key_left;
    logic               key_right;
    logic               key_rise;
    logic               key_sink;
    logic        [15:0] frame_time;
  } flc_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] yaw_now;
    logic signed [23:0] pitch_now;
  } flc_out_t;

  localparam logic [1:0] REG_SENS   = 2'd0;
  localparam logic [1:0] REG_SMOOTH = 2'd1;
  localparam logic [1:0] REG_SPEED  = 2'd2;

  localparam logic signed [39:0] DEG89  = 40'sd5832704;
  localparam logic signed [39:0] DEG90  = 40'sd5898240;
  localparam logic signed [39:0] DEG180 = 40'sd11796480;
  localparam logic signed [39:0] DEG360 = 40'sd23592960;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032875;
  localparam logic signed [39:0] I32_MAX = 40'sd2147483647;
  localparam logic signed [39:0] I32_MIN = -40'sd2147483648;

  // micro-operation codes issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GOALS, OP_SMUL, OP_SADD, OP_RED_START, OP_RED_STEP,
    OP_CORDIC, OP_CORDIC_END, OP_FRONT_MUL, OP_MOVE_MUL, OP_POS
  } flc_op_t;

  typedef struct packed {
    flc_op_t    op;
    logic [3:0] step;
    logic [1:0] sel;
  } flc_cmd_t;

  typedef struct packed {
    logic red_done;
  } flc_sts_t;

  function automatic logic signed [33:0] atan_lookup(input logic [3:0] i);
    logic signed [33:0] v;
    case (i)
      4'd0: v = 34'sd2949120;
      4'd1: v = 34'sd1740967;
      4'd2: v = 34'sd919879;
      4'd3: v = 34'sd466945;
      4'd4: v = 34'sd234379;
      4'd5: v = 34'sd117304;
      4'd6: v = 34'sd58666;
      4'd7: v = 34'sd29335;
      4'd8: v = 34'sd14668;
      4'd9: v = 34'sd7334;
      4'd10: v = 34'sd3667;
      4'd11: v = 34'sd1834;
      4'd12: v = 34'sd917;
      4'd13: v = 34'sd458;
      4'd14: v = 34'sd229;
      default: v = 34'sd115;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/free_look_camera_step_core.sv */
// Top level of the free-look camera step core: config registers, output register,
// controller and datapath. Depends on flc_pkg, flc_ctrl, flc_datapath.
//
//  channel   signals                               direction
//  in        in_valid, in_ready, in_data           item in
//  out       out_valid, out_ready, out_data        result out
//  cfg       cfg_valid, cfg_ready, cfg_index/data  register write
//
// The result is registered after the item passes the load and goal steps, the
// smoothing steps, two angle passes (start, settle, 16 CORDIC steps, rounding)
// and the shared multiplier and update steps; the next input is taken in the
// cycle after. Yaw reduction adds a step per 360-degree wrap and one for the
// fold. Reset is synchronous; a result
// not yet taken holds the core in its output state.
`timescale 1ns / 1ps
`default_nettype none
module free_look_camera_step_core
  import flc_pkg::*;
#(
  parameter int POS_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  flc_in_t          in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output flc_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  logic [15:0] sens;
  logic [16:0] smooth;
  logic [15:0] speed_cfg;
  flc_cmd_t cmd;
  flc_sts_t sts;
  flc_out_t result;
  logic out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens      <= 16'd26;
      smooth    <= 17'd65536;
      speed_cfg <= 16'd640;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENS:   sens      <= cfg_data[15:0];
        REG_SMOOTH: smooth    <= cfg_data;
        REG_SPEED:  speed_cfg <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  flc_ctrl u_ctrl (
    .clk, .rst,
    .in_fire (in_valid && in_ready),
    .out_busy(out_valid && !out_ready),
    .sts, .in_ready, .out_load, .cmd
  );

  flc_datapath #(.POS_WIDTH(POS_WIDTH)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .sens, .smooth, .speed_cfg, .sts, .result
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= result;
  end

endmodule
`default_nettype wire

/* hdl/flc_ctrl.sv */
// Controller state machine for the free-look camera step core.
// Depends on flc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module flc_ctrl
  import flc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_fire,
  input  wire logic     out_busy,
  input  flc_sts_t      sts,
  output logic          in_ready,
  output logic          out_load,
  output flc_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GOALS  = 4'd1;
  localparam logic [3:0] S_SMUL   = 4'd2;
  localparam logic [3:0] S_SADD   = 4'd3;
  localparam logic [3:0] S_REDS   = 4'd4;
  localparam logic [3:0] S_RED    = 4'd5;
  localparam logic [3:0] S_CORD   = 4'd6;
  localparam logic [3:0] S_CEND   = 4'd7;
  localparam logic [3:0] S_FMUL   = 4'd8;
  localparam logic [3:0] S_MMUL   = 4'd9;
  localparam logic [3:0] S_POS    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state, state_next;
  logic [3:0] step, step_next;
  logic [1:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    sel_next   = sel;
    cmd.op     = OP_NONE;
    cmd.step   = step;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.op     = OP_LOAD;
          state_next = S_GOALS;
        end
      end
      S_GOALS: begin
        cmd.op     = OP_GOALS;
        state_next = S_SMUL;
        sel_next   = 2'd0;
      end
      S_SMUL: begin
        cmd.op     = OP_SMUL;
        state_next = S_SADD;
      end
      S_SADD: begin
        cmd.op = OP_SADD;
        if (sel == 2'd1) begin
          sel_next   = 2'd0;
          state_next = S_REDS;
        end else begin
          sel_next   = 2'd1;
          state_next = S_SMUL;
        end
      end
      S_REDS: begin
        cmd.op     = OP_RED_START;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.op = OP_RED_STEP;
        if (sts.red_done) begin
          step_next  = '0;
          state_next = S_CORD;
        end
      end
      S_CORD: begin
        cmd.op    = OP_CORDIC;
        step_next = step + 4'd1;
        if (step == 4'd15) begin
          state_next = S_CEND;
        end
      end
      S_CEND: begin
        cmd.op = OP_CORDIC_END;
        if (sel == 2'd1) begin
          sel_next   = 2'd0;
          state_next = S_FMUL;
        end else begin
          sel_next   = 2'd1;
          state_next = S_REDS;
        end
      end
      S_FMUL: begin
        cmd.op = OP_FRONT_MUL;
        if (sel == 2'd1) begin
          sel_next   = 2'd0;
          state_next = S_MMUL;
        end else begin
          sel_next = 2'd1;
        end
      end
      S_MMUL: begin
        cmd.op = OP_MOVE_MUL;
        if (sel == 2'd3) begin
          sel_next   = 2'd0;
          state_next = S_POS;
        end else begin
          sel_next = sel + 2'd1;
        end
      end
      S_POS: begin
        cmd.op = OP_POS;
        if (sel == 2'd2) begin
          sel_next   = 2'd0;
          state_next = S_OUT;
        end else begin
          sel_next = sel + 2'd1;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/flc_datapath.sv */
// Datapath for the free-look camera step core: angles, shared CORDIC,
// shared multiplier and position accumulators. Depends on flc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module flc_datapath
  import flc_pkg::*;
#(
  parameter int POS_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  flc_in_t          in_item,
  input  flc_cmd_t         cmd,
  input  wire logic [15:0] sens,
  input  wire logic [16:0] smooth,
  input  wire logic [15:0] speed_cfg,
  output flc_sts_t         sts,
  output flc_out_t         result
);

  localparam int DW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 2;
  localparam logic signed [DW-1:0] PMAX =
    DW'((64'sd1 <<< (POS_WIDTH-1)) - 64'sd1);
  localparam logic signed [DW-1:0] PMIN = -PMAX - DW'(1);

  flc_in_t item;
  logic signed [31:0] yaw_angle, pitch_angle, goal_yaw, goal_pitch;
  logic signed [POS_WIDTH-1:0] pos [3];
  logic signed [POS_WIDTH-1:0] aim [3];

  logic signed [49:0] prod;            // registered product of the shared multiplier
  logic signed [39:0] red;             // angle under reduction
  logic               neg;
  logic signed [33:0] cx, cy, cz;      // CORDIC x, y and residual angle
  logic signed [15:0] sin_y, cos_y, sin_p, cos_p;
  logic signed [15:0] fx, fz;
  logic [23:0]        speed;
  logic signed [DW-1:0] dlt [3];

  // Saturate a 42-bit sum to 32 bits (goals and smoothed angles)
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > I32_MAX) return 32'sh7fffffff;
    if (v < I32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] psat(input logic signed [DW-1:0] v);
    if (v > PMAX) return PMAX[POS_WIDTH-1:0];
    if (v < PMIN) return PMIN[POS_WIDTH-1:0];
    return v[POS_WIDTH-1:0];
  endfunction

  // shared multiplier operands
  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic signed [41:0] gy_sum, gp_sum;
  logic signed [39:0] gp_sat;
  logic signed [32:0] diff;
  logic signed [39:0] sm_sum;
  logic signed [1:0]  fk, sk, uk;
  logic signed [17:0] comb_x, comb_z, comb_y;
  logic signed [33:0] cxs, cys;
  logic signed [15:0] cx_r, cy_r;
  logic signed [15:0] front_k;
  logic signed [DW-1:0] newpos;

  assign fk = $signed({1'b0, item.key_forward}) - $signed({1'b0, item.key_backward});
  assign sk = $signed({1'b0, item.key_right}) - $signed({1'b0, item.key_left});
  assign uk = $signed({1'b0, item.key_rise}) - $signed({1'b0, item.key_sink});

  assign gy_sum = 42'(goal_yaw) + 42'(prod);
  assign gp_sum = 42'(goal_pitch) + 42'(prod);
  assign gp_sat = 40'(sat32(gp_sum));
  assign diff   = (cmd.sel == 2'd0) ? 33'(goal_yaw) - 33'(yaw_angle)
                                    : 33'(goal_pitch) - 33'(pitch_angle);
  assign sm_sum = 40'((cmd.sel == 2'd0) ? yaw_angle : pitch_angle)
                + 40'((prod + 50'sd32768) >>> 16);

  // x: f*fx - s*sin y ; y: f*sin p ; z: f*fz + s*cos y
  always_comb begin
    comb_x = 18'(fk) * 18'(fx) - 18'(sk) * 18'(sin_y);
    comb_y = 18'(fk) * 18'(sin_p);
    comb_z = 18'(fk) * 18'(fz) + 18'(sk) * 18'(cos_y);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_LOAD: begin
        ma = 34'(in_item.mouse_dx) <<< 8;
        mb = $signed({2'b0, sens});
      end
      OP_GOALS: begin
        ma = 34'(item.mouse_dy) <<< 8;
        mb = $signed({2'b0, sens});
      end
      OP_SMUL: begin
        ma = 34'(diff);
        mb = $signed({1'b0, smooth > 17'd65536 ? 17'd65536 : smooth});
      end
      OP_FRONT_MUL: begin
        ma = (cmd.sel == 2'd0) ? 34'(cos_y) : 34'(sin_y);
        mb = 18'(cos_p);
      end
      OP_MOVE_MUL: begin
        case (cmd.sel)
          2'd0: begin ma = 34'($signed({1'b0, speed_cfg})); mb = $signed({2'b0, item.frame_time}); end
          2'd1: begin ma = 34'((prod + 50'sd128) >>> 8); mb = comb_x; end
          2'd2: begin ma = 34'($signed({1'b0, speed})); mb = comb_y; end
          default: begin ma = 34'($signed({1'b0, speed})); mb = comb_z; end
        endcase
      end
      default: ;
    endcase
  end

  assign cxs  = cx >>> cmd.step;
  assign cys  = cy >>> cmd.step;
  assign cx_r = 16'((cx + 34'sd32768) >>> 16);
  assign cy_r = 16'((cy + 34'sd32768) >>> 16);
  assign front_k = (cmd.sel == 2'd0) ? fx : ((cmd.sel == 2'd1) ? sin_p : fz);

  always_comb begin
    newpos = DW'(pos[cmd.sel]) + dlt[cmd.sel];
  end

  assign sts.red_done = (red < DEG180) && (red >= -DEG180) && (red <= DEG90)
                     && (red >= -DEG90);

  logic signed [DW-1:0] np_sat, aim_full;
  assign np_sat   = DW'(psat(newpos));
  assign aim_full = np_sat + DW'(front_k) * DW'(4);

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle   <= '0;
      pitch_angle <= '0;
      goal_yaw    <= '0;
      goal_pitch  <= '0;
      for (int k = 0; k < 3; k++) pos[k] <= '0;
    end else begin
      prod <= 50'(ma * 52'(mb)) <<< 0;
      case (cmd.op)
        OP_LOAD: item <= in_item;
        OP_GOALS: goal_yaw <= sat32(gy_sum);
        OP_SMUL: begin
          if (cmd.sel == 2'd0) begin
            if (gp_sat > DEG89) goal_pitch <= DEG89[31:0];
            else if (gp_sat < -DEG89) goal_pitch <= -32'sd5832704;
            else goal_pitch <= gp_sat[31:0];
          end
        end
        OP_SADD: begin
          if (cmd.sel == 2'd0) yaw_angle <= sat32(42'(sm_sum));
          else pitch_angle <= sat32(42'(sm_sum));
        end
        OP_RED_START: begin
          red <= 40'((cmd.sel == 2'd0) ? yaw_angle : pitch_angle);
          neg <= 1'b0;
        end
        OP_RED_STEP: begin
          if (red >= DEG180) red <= red - DEG360;
          else if (red < -DEG180) red <= red + DEG360;
          else if (red > DEG90) begin red <= red - DEG180; neg <= 1'b1; end
          else if (red < -DEG90) begin red <= red + DEG180; neg <= 1'b1; end
          else begin
            cx <= CORDIC_K;
            cy <= '0;
            cz <= 34'(red);
          end
        end
        OP_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - cys; cy <= cy + cxs; cz <= cz - atan_lookup(cmd.step);
          end else begin
            cx <= cx + cys; cy <= cy - cxs; cz <= cz + atan_lookup(cmd.step);
          end
        end
        OP_CORDIC_END: begin
          if (cmd.sel == 2'd0) begin
            cos_y <= neg ? -cx_r : cx_r; sin_y <= neg ? -cy_r : cy_r;
          end else begin
            cos_p <= neg ? -cx_r : cx_r; sin_p <= neg ? -cy_r : cy_r;
          end
        end
        OP_FRONT_MUL: ;
        OP_MOVE_MUL: ;
        OP_POS: begin
          pos[cmd.sel] <= psat(newpos);
          aim[cmd.sel] <= psat(aim_full);
        end
        default: ;
      endcase
    end
  end

  // results of the registered multiplier, captured one state later
  logic [1:0] mm_sel;
  logic       mm_v, fm_v;
  logic       fm_sel;
  always_ff @(posedge clk) begin
    if (rst) begin
      mm_v <= 1'b0;
      fm_v <= 1'b0;
    end else begin
      mm_v   <= (cmd.op == OP_MOVE_MUL);
      fm_v   <= (cmd.op == OP_FRONT_MUL);
      mm_sel <= cmd.sel;
      fm_sel <= cmd.sel[0];
      if (fm_v) begin
        if (!fm_sel) fx <= 16'((prod + 50'sd8192) >>> 14);
        else fz <= 16'((prod + 50'sd8192) >>> 14);
      end
      if (mm_v) begin
        case (mm_sel)
          2'd0: speed <= 24'((prod + 50'sd128) >>> 8);
          2'd1: dlt[0] <= DW'((prod + 50'sd8192) >>> 14);
          2'd2: dlt[1] <= DW'((prod + 50'sd8192) >>> 14)
                        + DW'(uk) * DW'($signed({1'b0, speed}));
          default: dlt[2] <= DW'((prod + 50'sd8192) >>> 14);
        endcase
      end
    end
  end

  assign result.pos_x     = 32'(pos[0]);
  assign result.pos_y     = 32'(pos[1]);
  assign result.pos_z     = 32'(pos[2]);
  assign result.aim_x     = 32'(aim[0]);
  assign result.aim_y     = 32'(aim[1]);
  assign result.aim_z     = 32'(aim[2]);
  assign result.yaw_now   = yaw_angle;
  assign result.pitch_now = pitch_angle[23:0];

endmodule
`default_nettype wire

/* hdl/flc_checker.sv */
// Port-level checker for the free-look camera step core, bound to the top level.
// Depends on flc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module flc_checker
  import flc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input flc_out_t      out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("transfer dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted during work");
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pitch_now <= 24'sd5832704 && out_data.pitch_now >= -24'sd5832704))
    else $error("pitch out of range");
  a_no_out_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("early result");

endmodule

bind free_look_camera_step_core flc_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
